FILE: rtl/core/bpw_pkg.sv
package bpw_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MA_W       = 32;
	localparam int MB_W       = 24;
	localparam int PROD_W     = MA_W + MB_W;
	localparam int DVD_W      = 61;
	localparam int DVS_W      = 46;
	localparam int QUO_W      = 16;
	localparam int SIN_IDX_W  = 10;
	localparam int TANH_IDX_W = 10;

	localparam logic [15:0] INTENSITY_RST = 16'd32768;

	// 135135 << 24, shared leading term of the Pade numerator and denominator
	localparam logic [DVS_W-1:0] TANH_K = 46'd2267189084160;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INC,
		S_SPE,
		S_SPO,
		S_AE,
		S_AO,
		S_XE,
		S_XO,
		S_SIN0,
		S_SIN1,
		S_SIN2,
		S_SIN3,
		S_SIN4,
		S_SIN5,
		S_SUM,
		S_PRE,
		S_T0,
		S_T1,
		S_T2,
		S_T3,
		S_T4,
		S_T5,
		S_T6,
		S_T7,
		S_T8,
		S_T9,
		S_DIV,
		S_DONE
	} bpw_state_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} bpw_div_st_t;

	// angle quantised to the sine grid, folded to a quarter wave
	function automatic logic [14:0] fold_mag(input logic [15:0] ang);
		logic [16:0] t;
		logic [16:0] m;
		t = {1'b0, ang[15:16-SIN_IDX_W], {(16-SIN_IDX_W){1'b0}}};
		if (t <= 17'd16384) begin
			m = t;
		end else if (t <= 17'd32768) begin
			m = 17'd32768 - t;
		end else if (t < 17'd49152) begin
			m = t - 17'd32768;
		end else begin
			m = 17'd65536 - t;
		end
		return m[14:0];
	endfunction

	function automatic logic fold_neg(input logic [15:0] ang);
		logic [16:0] t;
		t = {1'b0, ang[15:16-SIN_IDX_W], {(16-SIN_IDX_W){1'b0}}};
		return (t > 17'd32768);
	endfunction

	// floor(x*spread / 2^15) mod one turn, from the magnitude product
	function automatic logic [15:0] ang_of(input logic [PROD_W-1:0] p, input logic neg);
		logic [PROD_W-1:0] s;
		s = neg ? (~p + {{(PROD_W-1){1'b0}}, 1'b1}) : p;
		return s[30:15];
	endfunction

endpackage

FILE: rtl/core/bpw_in_if.sv
interface bpw_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [bpw_pkg::SAMPLE_W-1:0] sample_in;
	logic                                restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink (input valid, input sample_in, input restart, output ready);
endinterface

FILE: rtl/core/bpw_out_if.sv
interface bpw_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bpw_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

FILE: rtl/core/bell_phase_waveshaper.sv
// Bell phase waveshaper.
// din carries one signed Q1.15 sample and a restart flag per beat; dout carries
// the shaped Q1.15 sample. Both are valid/ready channels, a beat moving on a
// rising edge with valid and ready high. cfg_we/cfg_wdata write the Q0.16
// intensity; write it only while no sample is in flight.
// Each sample is worked through one shared 32x24 multiplier under a step
// sequencer, followed by a 16-step restoring divider for the tanh Pade ratio.
// din.ready is high only while the sequencer is idle. The result reaches the
// output register as the sequencer leaves S_DONE and the next beat can be
// taken at the edge after that, so no new sample is taken before the last one
// is finished; the multiplier steps and the divider make up its work.
// The output register holds its beat until dout.ready; meanwhile the block
// takes and works the next sample, then waits with it finished until the
// register frees.
// Reset clears the phase, sets intensity to one half and empties the output.
module bell_phase_waveshaper (
	input  logic              clk,
	input  logic              arst_n,
	bpw_in_if.sink            din,
	bpw_out_if.source         dout,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);

	bpw_pkg::bpw_state_t state_q, state_n;

	logic [15:0]                 iv_q;
	logic [15:0]                 x_q;
	logic                        rst_q;
	logic [15:0]                 phase_q;
	logic [17:0]                 sp_e_q;
	logic [16:0]                 sp_o_q;
	logic [14:0]                 amp_e_q;
	logic [13:0]                 k_q;
	logic [15:0]                 ang_q;
	logic [15:0]                 ang_o_q;
	logic                        sel_q;
	logic [14:0]                 m_q;
	logic [14:0]                 m2_q;
	logic                        sneg_q;
	logic [15:0]                 even_q;
	logic [15:0]                 odd_q;
	logic                        pneg_q;
	logic                        tneg_q;
	logic [bpw_pkg::TANH_IDX_W-1:0] idx_q;
	logic [15:0]                 u_q;
	logic [31:0]                 u2_q;
	logic [43:0]                 num_q;
	logic [bpw_pkg::DVS_W-1:0]   den_q;
	logic [38:0]                 lo_q;
	logic                        ov_q;
	logic [15:0]                 od_q;

	logic [bpw_pkg::MA_W-1:0]    mul_a;
	logic [bpw_pkg::MB_W-1:0]    mul_b;
	logic [bpw_pkg::PROD_W-1:0]  p;
	logic                        div_start;
	bpw_pkg::bpw_div_st_t        div_st;

	logic [36:0]                 rnd;
	logic [15:0]                 xm;
	logic [15:0]                 ang_x;
	logic [15:0]                 cur_ang;
	logic [14:0]                 fm;
	logic                        fn;
	logic [14:0]                 amp;
	logic [14:0]                 drive;
	logic [14:0]                 ysat;
	logic [15:0]                 term;
	logic [16:0]                 ssum;
	logic [16:0]                 smag;
	logic [bpw_pkg::TANH_IDX_W-1:0] idx_n;
	logic [36:0]                 u3;
	logic [16:0]                 xk;
	logic [bpw_pkg::DVD_W-1:0]   dvd;
	logic [14:0]                 yq;
	logic [15:0]                 yout;
	logic                        out_free;

	bpw_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p)
	);

	bpw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (dvd),
		.dvs    (den_q),
		.st     (div_st)
	);

	assign rnd     = p[36:0] + 37'd32768;
	assign xm      = x_q[15] ? (~x_q + 16'd1) : x_q;
	assign ang_x   = bpw_pkg::ang_of(p, x_q[15]);
	assign cur_ang = sel_q ? ang_o_q : ang_q;
	assign fm      = bpw_pkg::fold_mag(cur_ang);
	assign fn      = bpw_pkg::fold_neg(cur_ang);
	assign amp     = sel_q ? (15'd6554 + {1'b0, k_q}) : amp_e_q;
	assign drive   = 15'd18022 + {1'b0, k_q};
	assign ysat    = p[28] ? 15'h7FFF : {p[27:14], 1'b0};
	assign term    = sneg_q ? (16'd0 - {1'b0, p[29:15]}) : {1'b0, p[29:15]};
	assign ssum    = {even_q[15], even_q} + {odd_q[15], odd_q};
	assign smag    = ssum[16] ? (17'd0 - ssum) : ssum;
	assign idx_n   = (|p[bpw_pkg::PROD_W-1:31]) ? '1 : p[30:21];
	assign u3      = p[48:12];
	assign xk      = {idx_q, 7'b0};
	assign dvd     = {22'd0, lo_q} + {p[38:0], 22'd0};
	assign yq      = div_st.quo[bpw_pkg::QUO_W-1] ? 15'h7FFF : div_st.quo[14:0];
	assign yout    = tneg_q ? (16'd0 - {1'b0, yq}) : {1'b0, yq};
	assign out_free = !ov_q || dout.ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			bpw_pkg::S_IDLE: if (din.valid) state_n = bpw_pkg::S_INC;
			bpw_pkg::S_INC:  state_n = bpw_pkg::S_SPE;
			bpw_pkg::S_SPE:  state_n = bpw_pkg::S_SPO;
			bpw_pkg::S_SPO:  state_n = bpw_pkg::S_AE;
			bpw_pkg::S_AE:   state_n = bpw_pkg::S_AO;
			bpw_pkg::S_AO:   state_n = bpw_pkg::S_XE;
			bpw_pkg::S_XE:   state_n = bpw_pkg::S_XO;
			bpw_pkg::S_XO:   state_n = bpw_pkg::S_SIN0;
			bpw_pkg::S_SIN0: state_n = bpw_pkg::S_SIN1;
			bpw_pkg::S_SIN1: state_n = bpw_pkg::S_SIN2;
			bpw_pkg::S_SIN2: state_n = bpw_pkg::S_SIN3;
			bpw_pkg::S_SIN3: state_n = bpw_pkg::S_SIN4;
			bpw_pkg::S_SIN4: state_n = bpw_pkg::S_SIN5;
			bpw_pkg::S_SIN5: state_n = sel_q ? bpw_pkg::S_SUM : bpw_pkg::S_SIN0;
			bpw_pkg::S_SUM:  state_n = bpw_pkg::S_PRE;
			bpw_pkg::S_PRE:  state_n = bpw_pkg::S_T0;
			bpw_pkg::S_T0:   state_n = bpw_pkg::S_T1;
			bpw_pkg::S_T1:   state_n = bpw_pkg::S_T2;
			bpw_pkg::S_T2:   state_n = bpw_pkg::S_T3;
			bpw_pkg::S_T3:   state_n = bpw_pkg::S_T4;
			bpw_pkg::S_T4:   state_n = bpw_pkg::S_T5;
			bpw_pkg::S_T5:   state_n = bpw_pkg::S_T6;
			bpw_pkg::S_T6:   state_n = bpw_pkg::S_T7;
			bpw_pkg::S_T7:   state_n = bpw_pkg::S_T8;
			bpw_pkg::S_T8:   state_n = bpw_pkg::S_T9;
			bpw_pkg::S_T9:   state_n = bpw_pkg::S_DIV;
			bpw_pkg::S_DIV:  if (div_st.done) state_n = bpw_pkg::S_DONE;
			bpw_pkg::S_DONE: if (out_free) state_n = bpw_pkg::S_IDLE;
			default:         state_n = bpw_pkg::S_IDLE;
		endcase
	end

	// multiplier operands per step; the product is taken one step later
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		din.ready = 1'b0;
		case (state_q)
			bpw_pkg::S_IDLE: din.ready = 1'b1;
			bpw_pkg::S_INC: begin
				mul_a = {16'd0, iv_q};
				mul_b = 24'd2608;
			end
			bpw_pkg::S_SPE: begin
				mul_a = {16'd0, iv_q};
				mul_b = 24'd146025;
			end
			bpw_pkg::S_SPO: begin
				mul_a = {16'd0, iv_q};
				mul_b = 24'd73013;
			end
			bpw_pkg::S_AE: begin
				mul_a = {16'd0, iv_q};
				mul_b = 24'd13107;
			end
			bpw_pkg::S_AO: begin
				mul_a = {16'd0, iv_q};
				mul_b = 24'd9830;
			end
			bpw_pkg::S_XE: begin
				mul_a = {16'd0, xm};
				mul_b = {6'd0, sp_e_q};
			end
			bpw_pkg::S_XO: begin
				mul_a = {16'd0, xm};
				mul_b = {7'd0, sp_o_q};
			end
			bpw_pkg::S_SIN0: begin
				mul_a = {17'd0, fm};
				mul_b = {9'd0, fm};
			end
			bpw_pkg::S_SIN1: begin
				mul_a = {17'd0, p[28:14]};
				mul_b = 24'd1231;
			end
			bpw_pkg::S_SIN2: begin
				mul_a = {17'd0, m2_q};
				mul_b = {10'd0, 14'd10583 - p[27:14]};
			end
			bpw_pkg::S_SIN3: begin
				mul_a = {17'd0, m_q};
				mul_b = {9'd0, 15'd25736 - p[28:14]};
			end
			bpw_pkg::S_SIN4: begin
				mul_a = {17'd0, ysat};
				mul_b = {9'd0, amp};
			end
			bpw_pkg::S_SUM: begin
				mul_a = {15'd0, smag};
				mul_b = {9'd0, drive};
			end
			bpw_pkg::S_T0: begin
				mul_a = {22'd0, idx_q};
				mul_b = {14'd0, idx_q};
			end
			bpw_pkg::S_T1: begin
				mul_a = {16'd0, p[19:4]};
				mul_b = {8'd0, p[19:4]};
			end
			bpw_pkg::S_T2: begin
				mul_a = p[31:0];
				mul_b = {8'd0, u_q};
			end
			bpw_pkg::S_T3: begin
				mul_a = {16'd0, u_q};
				mul_b = 24'd17325;
			end
			bpw_pkg::S_T4: begin
				mul_a = {16'd0, u_q};
				mul_b = 24'd62370;
			end
			bpw_pkg::S_T5: begin
				mul_a = u2_q;
				mul_b = 24'd378;
			end
			bpw_pkg::S_T6: begin
				mul_a = u2_q;
				mul_b = 24'd3150;
			end
			bpw_pkg::S_T7: begin
				mul_a = {10'd0, num_q[21:0]};
				mul_b = {7'd0, xk};
			end
			bpw_pkg::S_T8: begin
				mul_a = {10'd0, num_q[43:22]};
				mul_b = {7'd0, xk};
			end
			bpw_pkg::S_T9: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpw_pkg::S_IDLE;
			iv_q    <= bpw_pkg::INTENSITY_RST;
			phase_q <= '0;
			sel_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				iv_q <= cfg_wdata;
			end
			if (state_q == bpw_pkg::S_SPE) begin
				phase_q <= (rst_q ? 16'd0 : phase_q) + 16'd1043 + rnd[31:16];
			end
			if (state_q == bpw_pkg::S_XO) begin
				sel_q <= 1'b0;
			end else if (state_q == bpw_pkg::S_SIN5) begin
				sel_q <= 1'b1;
			end
			if (state_q == bpw_pkg::S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bpw_pkg::S_IDLE: begin
				x_q   <= din.sample_in;
				rst_q <= din.restart;
			end
			bpw_pkg::S_SPO:  sp_e_q  <= 18'd62582 + rnd[33:16];
			bpw_pkg::S_AE:   sp_o_q  <= 17'd52152 + rnd[32:16];
			bpw_pkg::S_AO:   amp_e_q <= 15'd13107 + p[30:16];
			bpw_pkg::S_XE:   k_q     <= p[29:16];
			bpw_pkg::S_XO:   ang_q   <= ang_x + phase_q;
			bpw_pkg::S_SIN0: begin
				if (!sel_q) begin
					ang_o_q <= ang_x;
				end
				m_q    <= fm;
				sneg_q <= fn;
			end
			bpw_pkg::S_SIN1: m2_q <= p[28:14];
			bpw_pkg::S_SIN5: begin
				if (sel_q) begin
					odd_q <= term;
				end else begin
					even_q <= term;
				end
			end
			bpw_pkg::S_SUM:  pneg_q <= ssum[16];
			bpw_pkg::S_PRE: begin
				idx_q  <= idx_n;
				tneg_q <= pneg_q;
			end
			bpw_pkg::S_T1:   u_q  <= p[19:4];
			bpw_pkg::S_T2:   u2_q <= p[31:0];
			bpw_pkg::S_T3: begin
				num_q <= bpw_pkg::TANH_K[43:0] + {7'd0, u3};
				den_q <= bpw_pkg::TANH_K + ({4'd0, u3, 5'd0} - {7'd0, u3, 2'd0});
			end
			bpw_pkg::S_T4:   num_q <= num_q + {p[31:0], 12'd0};
			bpw_pkg::S_T5:   den_q <= den_q + {2'd0, p[31:0], 12'd0};
			bpw_pkg::S_T6:   num_q <= num_q + p[43:0];
			bpw_pkg::S_T7:   den_q <= den_q + p[45:0];
			bpw_pkg::S_T8:   lo_q  <= p[38:0];
			bpw_pkg::S_DONE: begin
				if (out_free) begin
					od_q <= yout;
				end
			end
			default: begin
			end
		endcase
	end

	assign dout.valid      = ov_q;
	assign dout.sample_out = od_q;

	ap_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bpw_pkg::S_SPE) |=> $stable(phase_q))
		else $error("phase moved outside its update step");

	ap_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == bpw_pkg::S_DIV))
		else $error("divider finished while sequencer not waiting");

	ap_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |=> (state_q == bpw_pkg::S_INC))
		else $error("accepted beat did not start the sequence");

	ap_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpw_pkg::S_DONE && out_free) |=>
		(dout.valid && state_q == bpw_pkg::S_IDLE))
		else $error("finished result not loaded to output");

endmodule

FILE: rtl/core/bpw_mul.sv
module bpw_mul (
	input  logic                        clk,
	input  logic [bpw_pkg::MA_W-1:0]    a,
	input  logic [bpw_pkg::MB_W-1:0]    b,
	output logic [bpw_pkg::PROD_W-1:0]  p_q
);

	always_ff @(posedge clk) begin
		p_q <= {{bpw_pkg::MB_W{1'b0}}, a} * {{bpw_pkg::MA_W{1'b0}}, b};
	end

endmodule

FILE: rtl/core/bpw_div.sv
module bpw_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bpw_pkg::DVD_W-1:0]  dvd,
	input  logic [bpw_pkg::DVS_W-1:0]  dvs,
	output bpw_pkg::bpw_div_st_t       st
);

	localparam int SH = bpw_pkg::DVD_W - bpw_pkg::DVS_W;

	logic                       busy_q;
	logic                       done_q;
	logic [3:0]                 cnt_q;
	logic [bpw_pkg::DVD_W-1:0]  rem_q;
	logic [bpw_pkg::DVD_W-1:0]  d_q;
	logic [bpw_pkg::QUO_W-1:0]  q_q;
	logic                       ge;

	assign ge = (rem_q >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(bpw_pkg::QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	// restoring, one quotient bit a cycle; top bit set means saturate
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dvd;
			d_q   <= {dvs, {SH{1'b0}}};
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - d_q;
			end
			d_q <= d_q >> 1;
			q_q <= {q_q[bpw_pkg::QUO_W-2:0], ge};
		end
	end

	assign st.done = done_q;
	assign st.quo  = q_q;

endmodule

FILE: test/tb_bell_phase_waveshaper.sv
module tb_bell_phase_waveshaper;

	localparam int LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 64;
	localparam int SINE_DEPTH = 1024;
	localparam int TANH_DEPTH = 1024;
	localparam logic [15:0] INTENSITY_AT_RESET = 16'd32768;
	localparam int ITEMS_PER_SETTING = 132;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	bpw_in_if  din_if ();
	bpw_out_if dout_if ();

	bell_phase_waveshaper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_if),
		.dout      (dout_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shaper state as the block should hold it
	logic [15:0]        intensity_q;
	logic [15:0]        osc_phase;
	logic signed [15:0] shaped_q [$];

	int errors;
	int n_sent;
	int n_restart;
	int n_checked;
	int n_cfg;
	int cycles;
	int snd_idle;
	int rcv_idle;
	int hold_req;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d beats pending", cycles, shaped_q.size());
		$display("status: fail");
		$finish;
	end

	function automatic longint mul_toward_zero(input longint a, input longint b, input int s);
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned r;
		ua = (a < 0) ? longint'(-a) : a;
		ub = (b < 0) ? longint'(-b) : b;
		r = (ua * ub) >> s;
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint sine_q15(input logic [15:0] ang);
		longint unsigned idx;
		longint unsigned t;
		longint unsigned m;
		longint unsigned m2;
		longint unsigned r;
		longint unsigned y;
		logic            neg;
		idx = (longint'(ang) * SINE_DEPTH) >> 16;
		t = (idx << 16) / SINE_DEPTH;
		if (t <= 16384) begin
			neg = 1'b0;
			m = t;
		end else if (t <= 32768) begin
			neg = 1'b0;
			m = 32768 - t;
		end else if (t < 49152) begin
			neg = 1'b1;
			m = t - 32768;
		end else begin
			neg = 1'b1;
			m = 65536 - t;
		end
		m2 = (m * m) >> 14;
		r = (m2 * 1231) >> 14;
		r = 10583 - r;
		r = (m2 * r) >> 14;
		r = 25736 - r;
		y = ((m * r) >> 14) << 1;
		if (y > 32767)
			y = 32767;
		return neg ? -longint'(y) : longint'(y);
	endfunction

	// Pade [7/6] at the table grid point below |v|
	function automatic longint tanh_q15(input longint v);
		logic            neg;
		longint unsigned m;
		longint unsigned idx;
		longint unsigned xk;
		longint unsigned xq;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned u3;
		longint unsigned num;
		longint unsigned den;
		longint unsigned y;
		neg = (v < 0);
		m = neg ? longint'(-v) : v;
		idx = (m * TANH_DEPTH) >> 17;
		if (idx > TANH_DEPTH - 1)
			idx = TANH_DEPTH - 1;
		xk = (idx << 17) / TANH_DEPTH;
		xq = xk >> 3;
		u = (xq * xq) >> 12;
		u2 = u * u;
		u3 = (u2 * u) >> 12;
		num = (64'd135135 << 24) + ((17325 * u) << 12) + 378 * u2 + u3;
		den = (64'd135135 << 24) + ((62370 * u) << 12) + 3150 * u2 + 28 * u3;
		y = (xk * num) / den;
		if (y > 32767)
			y = 32767;
		return neg ? -longint'(y) : longint'(y);
	endfunction

	// advances the phase and returns the shaped sample
	function automatic logic signed [15:0] shape_sample(input logic signed [15:0] x,
			input logic rst);
		longint unsigned iv;
		longint unsigned step;
		longint          spread_e;
		longint          spread_o;
		longint          prod;
		logic [15:0]     ang;
		longint          even_t;
		longint          odd_t;
		longint          pre;
		longint          y;
		iv = intensity_q;
		if (rst)
			osc_phase = 16'd0;
		step = 1043 + ((2608 * iv + 32768) >> 16);
		osc_phase = osc_phase + step[15:0];
		spread_e = 62582 + ((146025 * iv + 32768) >> 16);
		spread_o = 52152 + ((73013 * iv + 32768) >> 16);
		prod = longint'(x) * spread_e;
		ang = prod[30:15] + osc_phase;
		even_t = mul_toward_zero(sine_q15(ang), 13107 + ((13107 * iv) >> 16), 15);
		prod = longint'(x) * spread_o;
		ang = prod[30:15];
		odd_t = mul_toward_zero(sine_q15(ang), 6554 + ((9830 * iv) >> 16), 15);
		pre = mul_toward_zero(even_t + odd_t, 18022 + ((9830 * iv) >> 16), 14);
		y = tanh_q15(pre);
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return y[15:0];
	endfunction

	function automatic logic signed [15:0] pick_sample();
		logic signed [15:0] s;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(4))
					0: s = 16'sh7fff;
					1: s = 16'sh8000;
					2: s = 16'sh0000;
					3: s = 16'shffff;
					default: s = 16'sh0001;
				endcase
			end
			1: s = 16'($signed($urandom_range(512)) - 256);
			2: s = 16'($signed($urandom_range(8192)) - 4096);
			default: s = 16'($urandom);
		endcase
		return s;
	endfunction

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s on beat %0d, got %h, expected %h", what, n_checked, got,
				want);
	endtask

	// result side: check each beat, then choose ready for the next edge
	initial begin : result_side
		int                 hold_left;
		logic signed [15:0] want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (dout_if.valid && dout_if.ready) begin
				if (shaped_q.size() == 0) begin
					report("beat with nothing pending", dout_if.sample_out, 16'h0);
				end else begin
					want = shaped_q.pop_front();
					if (dout_if.sample_out !== want)
						report("sample_out", dout_if.sample_out, want);
					n_checked++;
				end
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end else if (rcv_idle > 0 && $urandom_range(199) == 0) begin
				hold_left = $urandom_range(60, 1);
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	task automatic send_sample(input logic signed [15:0] s, input logic rst);
		int gap;
		gap = 0;
		while ($urandom_range(99) < snd_idle)
			gap++;
		if (snd_idle > 0 && $urandom_range(7) == 0)
			gap += $urandom_range(55);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.sample_in <= s;
		din_if.restart <= rst;
		do @(posedge clk); while (!din_if.ready);
		shaped_q.push_back(shape_sample(s, rst));
		n_sent++;
		if (rst)
			n_restart++;
	endtask

	task automatic drain_out();
		din_if.valid <= 1'b0;
		while (shaped_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_intensity(input logic [15:0] v);
		drain_out();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		intensity_q = v;
		n_cfg++;
	endtask

	task automatic test_reset_defaults();
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'shffff, 1'b0);
		send_sample(16'sh4000, 1'b0);
		send_sample(16'shc000, 1'b1);
	endtask

	task automatic test_intensity_extremes();
		write_intensity(16'h0000);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh3039, 1'b0);
		write_intensity(16'hffff);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'shcfc7, 1'b0);
	endtask

	// zeros expose the phase alone; restart must pull it back to the first step
	task automatic test_restart();
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0000, 1'b1);
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
		logic [15:0] v;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: v = 16'h0000;
				1: v = 16'hffff;
				default: v = 16'($urandom);
			endcase
			write_intensity(v);
			snd_idle = snd_pct;
			rcv_idle = rcv_pct;
			for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
				if (i == ITEMS_PER_SETTING / 2)
					drain_out();
				send_sample(pick_sample(), $urandom_range(15) == 0);
			end
		end
	endtask

	task automatic test_output_hold();
		write_intensity(16'($urandom));
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 800;
		for (int i = 0; i < 40; i++)
			send_sample(pick_sample(), $urandom_range(7) == 0);
		drain_out();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 16'h0;
		din_if.valid = 1'b0;
		din_if.sample_in = 16'sh0;
		din_if.restart = 1'b0;
		dout_if.ready = 1'b0;
		intensity_q = INTENSITY_AT_RESET;
		osc_phase = 16'h0;
		errors = 0;
		n_sent = 0;
		n_restart = 0;
		n_checked = 0;
		n_cfg = 0;
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_intensity_extremes();
		test_restart();
		test_random_traffic(13, 72);
		test_random_traffic(72, 13);
		test_random_traffic(0, 0);
		test_output_hold();

		drain_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d of %0d samples shaped and checked (%0d with restart),",
			n_checked, n_sent, n_restart);
		$display("over %0d intensity writes, three stall mixes and one long output hold",
			n_cfg);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/bpw_pkg.sv
rtl/core/bpw_in_if.sv
rtl/core/bpw_out_if.sv
rtl/core/bpw_mul.sv
rtl/core/bpw_div.sv
rtl/core/bell_phase_waveshaper.sv
test/tb_bell_phase_waveshaper.sv
